@@ rtl/core/kmsf_pkg.sv @@
// Shared constants, types and command codes of the keypad matrix scanner.
package kmsf_pkg;

   localparam int ROW_BITS   = 7;
   localparam int COLUMNS    = 3;
   localparam int FIFO_DEPTH = 16;

   localparam int KEY_BITS   = ROW_BITS * COLUMNS;

   // Fixed field widths of the channels.
   localparam int ROW_IN_W   = 7;
   localparam int DRIVE_W    = 2;
   localparam int POP_WORD_W = 21;

   localparam int COL_IDX_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

   // Depth of the response buffer in the back end.
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   localparam logic [ROW_IN_W-1:0] ROW_MASK = ROW_IN_W'((1 << ROW_BITS) - 1);

   typedef enum logic [1:0] {
      CMD_NOP  = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_POP  = 2'd2
   } kmsf_cmd_kind_type;

   typedef struct packed {
      kmsf_cmd_kind_type    kind;
      logic [DRIVE_W-1:0]   drive_column;
      logic [KEY_BITS-1:0]  word;
   } kmsf_cmd_type;

   typedef struct packed {
      logic [DRIVE_W-1:0]    drive_column;
      logic                  pop_valid;
      logic [POP_WORD_W-1:0] pop_word;
      logic                  push_dropped;
   } kmsf_result_type;

endpackage

@@ rtl/core/kmsf_if.sv @@
// Valid/ready channel interfaces for scan requests and scan responses.
interface kmsf_req_if;
   import kmsf_pkg::*;
   logic                valid;
   logic                ready;
   logic                func;
   logic [ROW_IN_W-1:0] row_bits;

   modport source (output valid, output func, output row_bits, input ready);
   modport sink   (input valid, input func, input row_bits, output ready);
endinterface

interface kmsf_rsp_if;
   import kmsf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [DRIVE_W-1:0]    drive_column;
   logic                  pop_valid;
   logic [POP_WORD_W-1:0] pop_word;
   logic                  push_dropped;

   modport source (output valid, output drive_column, output pop_valid,
                   output pop_word, output push_dropped, input ready);
   modport sink   (input valid, input drive_column, input pop_valid,
                   input pop_word, input push_dropped, output ready);
endinterface

@@ rtl/core/keypad_matrix_scan_fifo.sv @@
// Top level of the keypad matrix scanner with its scan-word FIFO.
//
// Each request transaction is either a scan tick (func = 0), carrying the
// active-low row levels sampled while the current column was driven, or a
// pop (func = 1) that takes the oldest completed scan word out of a 16-word
// FIFO. Every request yields exactly one response transaction, in request
// order. The response always reports the column to drive for the next scan
// tick. After the third column the accumulated rows are inverted, so that a
// 1 means a pressed key, and the 21-bit word is stored; if the FIFO is full
// the word is discarded and push_dropped is set in that response. A pop of
// an empty FIFO returns pop_valid = 0 and a zero word. The block accepts one
// request transaction every clock cycle and delivers one response every
// cycle while the response side keeps ready high. A request's response
// passes through the command queue, the registered read of the FIFO RAM
// and the response buffer, in that order. The response buffer holds four
// entries, so short stalls on the response side do not immediately stop
// the request side.
module keypad_matrix_scan_fifo (
   input  logic       clock,
   input  logic       reset,
   kmsf_req_if.sink   req_channel,
   kmsf_rsp_if.source rsp_channel
);
   import kmsf_pkg::*;

   // Commands flow from the front end through the queue into the back end.
   kmsf_cmd_type front_cmd;
   kmsf_cmd_type queue_cmd;
   logic         front_push;
   logic         queue_full;
   logic         queue_valid;
   logic         back_pop;

   // The front end owns the column counter and the row accumulator.
   kmsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .cmd_full    (queue_full),
      .cmd_push    (front_push),
      .cmd_data    (front_cmd)
   );

   // The queue decouples request acceptance from FIFO and response stalls.
   kmsf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_push),
      .wr_data  (front_cmd),
      .full     (queue_full),
      .rd_en    (back_pop),
      .rd_valid (queue_valid),
      .rd_data  (queue_cmd)
   );

   // The back end owns the scan-word FIFO and builds the responses.
   kmsf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (queue_valid),
      .cmd_data    (queue_cmd),
      .cmd_pop     (back_pop),
      .rsp_channel (rsp_channel)
   );

endmodule

@@ rtl/core/kmsf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kmsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/kmsf_front.sv @@
// Front end: accepts transactions, accumulates column rows and issues commands.
module kmsf_front (
   input  logic                  clock,
   input  logic                  reset,
   kmsf_req_if.sink              req_channel,
   input  logic                  cmd_full,
   output logic                  cmd_push,
   output kmsf_pkg::kmsf_cmd_type cmd_data
);
   import kmsf_pkg::*;

   logic [COL_IDX_W-1:0] col_ff, col_in;
   logic [KEY_BITS-1:0]  acc_ff, acc_in;
   logic [KEY_BITS-1:0]  rows;
   logic [KEY_BITS-1:0]  acc_or;
   logic [7:0]           offset;
   logic                 last_col;
   logic                 accept;

   assign req_channel.ready = !cmd_full;
   assign accept            = req_channel.valid && !cmd_full;
   assign cmd_push          = accept;

   always_comb begin
      rows     = KEY_BITS'(req_channel.row_bits & ROW_MASK);
      offset   = 8'(col_ff) * 8'(ROW_BITS);
      acc_or   = acc_ff | (rows << offset);
      last_col = (col_ff == COL_IDX_W'(COLUMNS - 1));
      col_in   = col_ff;
      acc_in   = acc_ff;
      cmd_data.kind         = CMD_POP;
      cmd_data.drive_column = DRIVE_W'(col_ff);
      cmd_data.word         = ~acc_or;
      if (!req_channel.func) begin
         if (last_col) begin
            col_in        = '0;
            acc_in        = '0;
            cmd_data.kind = CMD_PUSH;
         end else begin
            col_in        = col_ff + COL_IDX_W'(1);
            acc_in        = acc_or;
            cmd_data.kind = CMD_NOP;
         end
         cmd_data.drive_column = DRIVE_W'(col_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         acc_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         acc_ff <= acc_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_IDX_W'(COLUMNS - 1))
      else $error("column counter beyond last column");

   assert property (@(posedge clock) disable iff (reset)
      accept && !req_channel.func && last_col |=> acc_ff == '0 && col_ff == '0)
      else $error("accumulator not cleared after last column");

   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(col_ff) && $stable(acc_ff))
      else $error("scan state changed without a transaction");

endmodule

@@ rtl/core/kmsf_cmd_queue.sv @@
// Two-entry command queue between the front end and the back end.
module kmsf_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  kmsf_pkg::kmsf_cmd_type wr_data,
   output logic                   full,
   input  logic                   rd_en,
   output logic                   rd_valid,
   output kmsf_pkg::kmsf_cmd_type rd_data
);
   import kmsf_pkg::*;

   kmsf_cmd_type entry_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_wr, do_rd;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_wr) wr_ptr_ff <= !wr_ptr_ff;
         if (do_rd) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(do_wr) - 2'(do_rd);
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("command queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      do_wr && !do_rd |=> count_ff == $past(count_ff) + 2'd1)
      else $error("command queue count lost a write");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("command queue pointers disagree when empty");

endmodule

@@ rtl/core/kmsf_back.sv @@
// Back end: scan-word FIFO, RAM read stage and response buffer.
module kmsf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  kmsf_pkg::kmsf_cmd_type cmd_data,
   output logic                   cmd_pop,
   kmsf_rsp_if.source             rsp_channel
);
   import kmsf_pkg::*;

   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               fifo_full, fifo_empty;
   logic               issue;
   logic               ram_wr;
   logic [KEY_BITS-1:0] ram_rd_data;

   // Read stage: the command issued last cycle, waiting for RAM data.
   logic               s1_valid_ff;
   logic [DRIVE_W-1:0] s1_drive_ff;
   logic               s1_pop_valid_ff;
   logic               s1_dropped_ff;

   kmsf_result_type        outq_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]  outq_wr_ff, outq_rd_ff;
   logic [OUTQ_CNT_W-1:0]  outq_count_ff;
   logic                   outq_pop;
   kmsf_result_type        s1_result;

   assign fifo_full  = (count_ff == COUNT_W'(FIFO_DEPTH));
   assign fifo_empty = (count_ff == '0);

   // Credit check: the read stage plus buffered responses must fit the buffer.
   assign issue   = cmd_valid &&
                    ((outq_count_ff + OUTQ_CNT_W'(s1_valid_ff)) < OUTQ_CNT_W'(OUTQ_DEPTH));
   assign cmd_pop = issue;
   assign ram_wr  = issue && (cmd_data.kind == CMD_PUSH) && !fifo_full;

   kmsf_ram #(.WIDTH(KEY_BITS), .DEPTH(FIFO_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (cmd_data.word),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_result.drive_column = s1_drive_ff;
      s1_result.pop_valid    = s1_pop_valid_ff;
      s1_result.pop_word     = s1_pop_valid_ff ? POP_WORD_W'(ram_rd_data) : '0;
      s1_result.push_dropped = s1_dropped_ff;
   end

   assign outq_pop           = rsp_channel.valid && rsp_channel.ready;
   assign rsp_channel.valid  = (outq_count_ff != '0);
   assign rsp_channel.drive_column = outq_ff[outq_rd_ff].drive_column;
   assign rsp_channel.pop_valid    = outq_ff[outq_rd_ff].pop_valid;
   assign rsp_channel.pop_word     = outq_ff[outq_rd_ff].pop_word;
   assign rsp_channel.push_dropped = outq_ff[outq_rd_ff].push_dropped;

   always_ff @(posedge clock) begin
      s1_drive_ff <= cmd_data.drive_column;
      if (s1_valid_ff) begin
         outq_ff[outq_wr_ff] <= s1_result;
      end
      if (reset) begin
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
         s1_valid_ff     <= 1'b0;
         s1_pop_valid_ff <= 1'b0;
         s1_dropped_ff   <= 1'b0;
         outq_wr_ff      <= '0;
         outq_rd_ff      <= '0;
         outq_count_ff   <= '0;
      end else begin
         s1_valid_ff     <= issue;
         s1_pop_valid_ff <= 1'b0;
         s1_dropped_ff   <= 1'b0;
         if (issue) begin
            unique case (cmd_data.kind)
               CMD_PUSH: begin
                  if (fifo_full) begin
                     s1_dropped_ff <= 1'b1;
                  end else begin
                     wr_ptr_ff <= (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                  : wr_ptr_ff + PTR_W'(1);
                     count_ff  <= count_ff + COUNT_W'(1);
                  end
               end
               CMD_POP: begin
                  if (!fifo_empty) begin
                     s1_pop_valid_ff <= 1'b1;
                     rd_ptr_ff <= (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                  : rd_ptr_ff + PTR_W'(1);
                     count_ff  <= count_ff - COUNT_W'(1);
                  end
               end
               CMD_NOP: begin
               end
               default: begin
               end
            endcase
         end
         if (s1_valid_ff) begin
            outq_wr_ff <= (outq_wr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                          : outq_wr_ff + OUTQ_PTR_W'(1);
         end
         if (outq_pop) begin
            outq_rd_ff <= (outq_rd_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                          : outq_rd_ff + OUTQ_PTR_W'(1);
         end
         outq_count_ff <= outq_count_ff + OUTQ_CNT_W'(s1_valid_ff) - OUTQ_CNT_W'(outq_pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(FIFO_DEPTH))
      else $error("scan FIFO count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      issue && cmd_data.kind == CMD_PUSH && fifo_full |=> s1_dropped_ff)
      else $error("full FIFO push not flagged as dropped");

   assert property (@(posedge clock) disable iff (reset)
      s1_pop_valid_ff |-> $past(count_ff) != '0)
      else $error("pop returned a word from an empty FIFO");

   assert property (@(posedge clock) disable iff (reset)
      (outq_count_ff + OUTQ_CNT_W'(s1_valid_ff)) <= OUTQ_CNT_W'(OUTQ_DEPTH))
      else $error("response buffer overcommitted");

endmodule
